[hdl/aprt_pkg.sv]
package aprt_pkg;

   // Shared serial divider: dividend and divisor widths.
   localparam int DIV_W  = 34;
   localparam int DVS_W  = 17;
   localparam int DCNT_W = 6;

   // Shared serial square root: radicand and root widths.
   localparam int SQ_W   = 32;
   localparam int ROOT_W = 16;
   localparam int SCNT_W = 4;

   // Fixed-point constants of the angle approximation.
   localparam logic [9:0]  UNIT         = 10'd1000;
   localparam logic [8:0]  ATAN_K       = 9'd281;
   localparam logic [15:0] RAD_TO_MDEG  = 16'd57296;
   localparam logic [16:0] QUARTER_TURN = 17'd90000;
   localparam logic [14:0] MG_LIMIT     = 15'h7fff;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SCALE_NUM = 2'd0,
      CSR_SCALE_DEN = 2'd1,
      CSR_TILT_THR  = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

endpackage

[hdl/aprt_div.sv]
module aprt_div
   import aprt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam logic [DCNT_W-1:0] LAST = DCNT_W'(DIV_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    rem_shift;
   logic [DVS_W:0]    diff;
   logic              ge;

   // One quotient bit per cycle: restoring division, quotient shifts in behind the dividend.
   assign rem_shift = {rem_ff, num_ff[DIV_W-1]};
   assign diff      = rem_shift - {1'b0, dvs_ff};
   assign ge        = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

[hdl/aprt_sqrt.sv]
module aprt_sqrt
   import aprt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam logic [SCNT_W-1:0] LAST = SCNT_W'(ROOT_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SCNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+3:0] rem_shift;
   logic [ROOT_W+3:0] trial;
   logic              ge;

   // One root bit per cycle: two radicand bits enter the partial remainder each step.
   assign rem_shift = {rem_ff, rad_ff[SQ_W-1:SQ_W-2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign ge        = rem_shift >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[SQ_W-3:0], 2'b00};
         rem_in  = ge ? ROOT_W'(0) + (ROOT_W+2)'(rem_shift - trial)
                      : (ROOT_W+2)'(rem_shift);
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hdl/accel_pitch_roll_tilt_unit.sv]
// Each accepted item takes eleven passes of the bit-serial divider and two square
// roots before its result is ready.
// A new item is taken only once the previous one has reached the output register,
// which holds it until it is taken.
// Reset (synchronous, active high) clears the sequencer, the output valid, the
// sample counter and returns the configuration registers to their reset values.
module accel_pitch_roll_tilt_unit
   import aprt_pkg::*;
#(
   parameter int RAW_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [RAW_WIDTH-1:0] req_accel_x_raw,
   input  logic signed [RAW_WIDTH-1:0] req_accel_y_raw,
   input  logic signed [RAW_WIDTH-1:0] req_accel_z_raw,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [15:0]          rsp_accel_x_mg,
   output logic signed [15:0]          rsp_accel_y_mg,
   output logic signed [15:0]          rsp_accel_z_mg,
   output logic signed [17:0]          rsp_pitch_mdeg,
   output logic signed [17:0]          rsp_roll_mdeg,
   output logic                        rsp_tilt_alert,
   output logic [31:0]                 rsp_sample_number,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [16:0]                 csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SCALE  = 10'b0000000010,
      ST_SQUARE = 10'b0000000100,
      ST_ROOT   = 10'b0000001000,
      ST_RATIO  = 10'b0000010000,
      ST_RSQ    = 10'b0000100000,
      ST_RDEN   = 10'b0001000000,
      ST_RATAN  = 10'b0010000000,
      ST_QUAD   = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic              issued_ff, issued_in;
   logic [1:0]        axis_ff, axis_in;
   logic              sel_ff, sel_in;
   logic [9:0]        num_ff;
   logic [15:0]       den_cfg_ff;
   logic [16:0]       thr_ff;
   logic [31:0]       count_ff, count_in;

   logic [RAW_WIDTH-1:0] mag_ff [3];
   logic                 neg_ff [3];
   logic [15:0]          mg_ff [3];
   logic [29:0]          sq_ff [3];
   logic [ROOT_W-1:0]    root_ff [2];
   logic [9:0]           t_ff;
   logic [9:0]           t2_ff;
   logic [10:0]          den_ff;
   logic [15:0]          at_ff;
   logic [17:0]          pitch_ff, roll_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       out_x_ff, out_y_ff, out_z_ff;
   logic [17:0]       out_pitch_ff, out_roll_ff;
   logic              out_tilt_ff;
   logic [31:0]       out_count_ff;

   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_dvd, div_quo;
   logic [DVS_W-1:0]  div_dvs;
   logic              sqrt_start, sqrt_done;
   logic [SQ_W-1:0]   sqrt_rad;
   logic [ROOT_W-1:0] sqrt_root;

   logic              accept, load_out;
   logic [RAW_WIDTH-1:0] raw_arr [3];

   // Magnitude of the raw counts is taken once, when the item is accepted.
   assign raw_arr[0] = req_accel_x_raw;
   assign raw_arr[1] = req_accel_y_raw;
   assign raw_arr[2] = req_accel_z_raw;
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= raw_arr[i][RAW_WIDTH-1];
            mag_ff[i] <= raw_arr[i][RAW_WIDTH-1] ? (~raw_arr[i] + 1'b1) : raw_arr[i];
         end
      end
   end

   // Scaling operands: magnitude times numerator over the denominator, zero read as one.
   logic [RAW_WIDTH+9:0] sc_prod;
   logic [15:0]          den_eff;
   logic [14:0]          sc_sat;
   logic [15:0]          sc_mg;
   assign sc_prod = mag_ff[axis_ff] * num_ff;
   assign den_eff = (den_cfg_ff == 16'd0) ? 16'd1 : den_cfg_ff;
   assign sc_sat  = (div_quo > DIV_W'(MG_LIMIT)) ? MG_LIMIT : div_quo[14:0];
   assign sc_mg   = neg_ff[axis_ff] ? (~{1'b0, sc_sat} + 1'b1) : {1'b0, sc_sat};

   // Square of one scaled axis per cycle.
   logic [15:0] mg_abs;
   assign mg_abs = mg_ff[axis_ff][15] ? (~mg_ff[axis_ff] + 1'b1) : mg_ff[axis_ff];

   // Operands of the current angle: the signed axis against the non-negative root.
   logic [15:0]        yv;
   logic [14:0]        ay;
   logic [ROOT_W-1:0]  ax;
   logic               swap, both_zero;
   logic [ROOT_W-1:0]  small_v, large_v;
   logic [16:0]        a_mag;
   logic [17:0]        ang;
   assign yv        = sel_ff ? mg_ff[1] : mg_ff[0];
   assign ay        = yv[15] ? 15'(~yv + 1'b1) : yv[14:0];
   assign ax        = root_ff[sel_ff];
   assign swap      = {1'b0, ay} > ax;
   assign both_zero = (ax == '0) && (ay == '0);
   assign small_v   = swap ? ax : {1'b0, ay};
   assign large_v   = swap ? {1'b0, ay} : ax;
   assign a_mag     = swap ? (QUARTER_TURN - {1'b0, at_ff}) : {1'b0, at_ff};
   assign ang       = both_zero ? 18'd0
                    : (yv[15] ? (~{1'b0, a_mag} + 1'b1) : {1'b0, a_mag});

   // Products feeding the shared divider, one per state.
   logic [25:0] ratio_prod;
   logic [19:0] tsq_prod;
   logic [18:0] den_prod;
   logic [25:0] atan_prod;
   assign ratio_prod = small_v * UNIT;
   assign tsq_prod   = t_ff * t_ff;
   assign den_prod   = t2_ff * ATAN_K;
   assign atan_prod  = t_ff * RAD_TO_MDEG;

   always_comb begin
      div_dvd = DIV_W'(sc_prod);
      div_dvs = DVS_W'(den_eff);
      unique case (state_ff)
         ST_RATIO: begin
            div_dvd = DIV_W'(ratio_prod);
            div_dvs = DVS_W'(large_v);
         end
         ST_RSQ: begin
            div_dvd = DIV_W'(tsq_prod);
            div_dvs = DVS_W'(UNIT);
         end
         ST_RDEN: begin
            div_dvd = DIV_W'(den_prod);
            div_dvs = DVS_W'(UNIT);
         end
         ST_RATAN: begin
            div_dvd = DIV_W'(atan_prod);
            div_dvs = DVS_W'(den_ff);
         end
         default: begin
            div_dvd = DIV_W'(sc_prod);
            div_dvs = DVS_W'(den_eff);
         end
      endcase
   end

   assign div_start  = !issued_ff && ((state_ff == ST_SCALE) || (state_ff == ST_RATIO) ||
                       (state_ff == ST_RSQ) || (state_ff == ST_RDEN) || (state_ff == ST_RATAN));
   assign sqrt_start = !issued_ff && (state_ff == ST_ROOT);
   assign sqrt_rad   = (axis_ff == 2'd0) ? SQ_W'({1'b0, sq_ff[1]} + {1'b0, sq_ff[2]})
                                         : SQ_W'({1'b0, sq_ff[0]} + {1'b0, sq_ff[2]});

   aprt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   aprt_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Sequencer over the steps of one item.
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      axis_in   = axis_ff;
      sel_in    = sel_ff;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_SCALE;
               axis_in   = 2'd0;
               issued_in = 1'b0;
            end
         end
         ST_SCALE: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  state_in = ST_SQUARE;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         ST_SQUARE: begin
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = ST_ROOT;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (sqrt_done) begin
               issued_in = 1'b0;
               if (axis_ff == 2'd1) begin
                  sel_in   = 1'b0;
                  state_in = ST_RATIO;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         ST_RATIO, ST_RSQ, ST_RDEN, ST_RATAN: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  ST_RATIO: state_in = ST_RSQ;
                  ST_RSQ:   state_in = ST_RDEN;
                  ST_RDEN:  state_in = ST_RATAN;
                  default:  state_in = ST_QUAD;
               endcase
            end
         end
         ST_QUAD: begin
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_RATIO;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in  = ST_IDLE;
            issued_in = 1'b0;
         end
      endcase
   end

   // Intermediate results written back as each step finishes.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCALE) && issued_ff && div_done) begin
         mg_ff[axis_ff] <= sc_mg;
      end
      if (state_ff == ST_SQUARE) begin
         sq_ff[axis_ff] <= mg_abs[14:0] * mg_abs[14:0];
      end
      if ((state_ff == ST_ROOT) && issued_ff && sqrt_done) begin
         root_ff[axis_ff[0]] <= sqrt_root;
      end
      if (issued_ff && div_done) begin
         if (state_ff == ST_RATIO) t_ff   <= div_quo[9:0];
         if (state_ff == ST_RSQ)   t2_ff  <= div_quo[9:0];
         if (state_ff == ST_RDEN)  den_ff <= 11'(UNIT) + div_quo[10:0];
         if (state_ff == ST_RATAN) at_ff  <= div_quo[15:0];
      end
      if (state_ff == ST_QUAD) begin
         if (sel_ff) roll_ff  <= ang;
         else        pitch_ff <= ang;
      end
   end

   // Output register and tilt decision.
   logic [17:0] pitch_abs;
   assign pitch_abs    = pitch_ff[17] ? (~pitch_ff + 1'b1) : pitch_ff;
   assign count_in     = load_out ? count_ff + 1'b1 : count_ff;
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_x_ff     <= mg_ff[0];
         out_y_ff     <= mg_ff[1];
         out_z_ff     <= mg_ff[2];
         out_pitch_ff <= pitch_ff;
         out_roll_ff  <= roll_ff;
         out_tilt_ff  <= pitch_abs > {1'b0, thr_ff};
         out_count_ff <= count_ff + 1'b1;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         axis_ff      <= 2'd0;
         sel_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         num_ff       <= 10'd61;
         den_cfg_ff   <= 16'd1000;
         thr_ff       <= 17'd45000;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         axis_ff      <= axis_in;
         sel_ff       <= sel_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_SCALE_NUM: num_ff     <= csr_wdata[9:0];
               CSR_SCALE_DEN: den_cfg_ff <= csr_wdata[15:0];
               CSR_TILT_THR:  thr_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accel_x_mg    = out_x_ff;
   assign rsp_accel_y_mg    = out_y_ff;
   assign rsp_accel_z_mg    = out_z_ff;
   assign rsp_pitch_mdeg    = out_pitch_ff;
   assign rsp_roll_mdeg     = out_roll_ff;
   assign rsp_tilt_alert    = out_tilt_ff;
   assign rsp_sample_number = out_count_ff;

endmodule

[hdl/aprt_checker.sv]
module aprt_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_accel_x_mg,
   input logic signed [15:0] rsp_accel_y_mg,
   input logic signed [17:0] rsp_pitch_mdeg,
   input logic               rsp_tilt_alert,
   input logic [31:0]        rsp_sample_number
);

   // A waiting result item stays valid and keeps its sample number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_number))
      else $error("result item changed while stalled");

   // Saturation never yields the most negative code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accel_x_mg != -16'sd32768) && (rsp_accel_y_mg != -16'sd32768))
      else $error("scaled value outside saturation range");

   // Pitch stays within a quarter turn either way.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_mdeg <= 18'sd90000) && (rsp_pitch_mdeg >= -18'sd90000))
      else $error("pitch out of range");

   // A tilt alert needs a non-zero pitch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tilt_alert |-> rsp_pitch_mdeg != 18'sd0)
      else $error("tilt alert with level pitch");

endmodule

bind accel_pitch_roll_tilt_unit aprt_checker u_aprt_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb
   import aprt_pkg::*;
();

   localparam int RAW_W      = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int LATENCY    = 600;

   // Expected contents of one result item.
   typedef struct packed {
      logic signed [15:0] x_mg;
      logic signed [15:0] y_mg;
      logic signed [15:0] z_mg;
      logic signed [17:0] pitch;
      logic signed [17:0] roll;
      logic               tilt;
      logic [31:0]        sample_no;
   } tilt_result_type;

   // Scoreboard: predicts the attitude of each accepted sample and checks results.
   class attitude_scoreboard_type;
      tilt_result_type pending_q[$];
      int unsigned  mismatches;
      int unsigned  num_reg;
      int unsigned  den_reg;
      int unsigned  thr_reg;
      logic [31:0]  seen_total;

      function void clear_state();
         num_reg    = 61;
         den_reg    = 1000;
         thr_reg    = 45000;
         seen_total = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [16:0] value);
         case (idx)
            CSR_SCALE_NUM: num_reg = 32'(value[9:0]);
            CSR_SCALE_DEN: den_reg = 32'(value[15:0]);
            CSR_TILT_THR:  thr_reg = 32'(value);
            default: ;
         endcase
      endfunction

      function longint scale_mg(logic signed [RAW_W-1:0] raw);
         longint mag;
         longint q;
         longint div;
         mag = (raw < 0) ? -longint'(raw) : longint'(raw);
         div = (den_reg == 0) ? 1 : den_reg;
         q   = mag * num_reg / div;
         if (q > 32767) q = 32767;
         return (raw < 0) ? -q : q;
      endfunction

      function longint isqrt(longint n);
         longint lo;
         longint hi;
         longint mid;
         lo = 0;
         hi = 65536;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= n) lo = mid;
            else hi = mid;
         end
         return lo;
      endfunction

      function longint atan_part(longint sm, longint lg);
         longint t;
         longint t2;
         longint d;
         t  = sm * 1000 / lg;
         t2 = t * t / 1000;
         d  = 1000 + 281 * t2 / 1000;
         return t * 57296 / d;
      endfunction

      function longint angle(longint y, longint x);
         longint ay;
         longint ax;
         longint a;
         if (x == 0 && y == 0) return 0;
         ay = (y < 0) ? -y : y;
         ax = (x < 0) ? -x : x;
         if (ax >= ay) a = atan_part(ay, ax);
         else a = 90000 - atan_part(ax, ay);
         if (x < 0 && y >= 0) a = 180000 - a;
         else if (x < 0) a = a - 180000;
         else if (y < 0) a = -a;
         return a;
      endfunction

      // Notes an accepted item and queues the result it should produce.
      function void note_sample(logic signed [RAW_W-1:0] xr, logic signed [RAW_W-1:0] yr,
                                logic signed [RAW_W-1:0] zr);
         tilt_result_type e;
         longint xm;
         longint ym;
         longint zm;
         longint p;
         longint r;
         xm = scale_mg(xr);
         ym = scale_mg(yr);
         zm = scale_mg(zr);
         p  = angle(xm, isqrt(ym * ym + zm * zm));
         r  = angle(ym, isqrt(xm * xm + zm * zm));
         seen_total = seen_total + 1;
         e.x_mg      = xm[15:0];
         e.y_mg      = ym[15:0];
         e.z_mg      = zm[15:0];
         e.pitch     = p[17:0];
         e.roll      = r[17:0];
         e.tilt      = (((p < 0) ? -p : p) > thr_reg);
         e.sample_no = seen_total;
         pending_q.push_back(e);
      endfunction

      // Compares one result item with the oldest expectation.
      function void check_result(tilt_result_type got);
         tilt_result_type e;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result item: %p", got);
            return;
         end
         e = pending_q.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", e, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [RAW_W-1:0] req_accel_x_raw;
   logic signed [RAW_W-1:0] req_accel_y_raw;
   logic signed [RAW_W-1:0] req_accel_z_raw;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [15:0] rsp_accel_x_mg;
   logic signed [15:0] rsp_accel_y_mg;
   logic signed [15:0] rsp_accel_z_mg;
   logic signed [17:0] rsp_pitch_mdeg;
   logic signed [17:0] rsp_roll_mdeg;
   logic rsp_tilt_alert;
   logic [31:0] rsp_sample_number;
   logic csr_we;
   logic [1:0] csr_index;
   logic [16:0] csr_wdata;

   attitude_scoreboard_type sb;
   int unsigned idle_cycles;
   bit stim_done;

   accel_pitch_roll_tilt_unit #(.RAW_WIDTH(RAW_W)) u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Short gaps mostly, an occasional long one, and runs with none.
   function automatic int unsigned gap_len();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) return 0;
      if (sel < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 700);
   endfunction

   // Result side: random stalls, checks at the rising edge.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_accel_x_mg, rsp_accel_y_mg, rsp_accel_z_mg, rsp_pitch_mdeg,
                          rsp_roll_mdeg, rsp_tilt_alert, rsp_sample_number});
   end

   // Input side: note accepted items.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_sample(req_accel_x_raw, req_accel_y_raw, req_accel_z_raw);
   end

   // Watchdog on cycles without any accepted item, delivered result or register write.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Valid drops only when a gap follows; a back-to-back item replaces the payload at once.
   task automatic send_sample(int xr, int yr, int zr);
      int unsigned gap;
      gap = gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_accel_x_raw <= RAW_W'(xr);
      req_accel_y_raw <= RAW_W'(yr);
      req_accel_z_raw <= RAW_W'(zr);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [16:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   // Waits until every expected result has arrived and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic random_burst(int unsigned count);
      logic signed [RAW_W-1:0] v[3];
      for (int unsigned n = 0; n < count; n++) begin
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
               0: v[k] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
               1: v[k] = RAW_W'($urandom_range(0, 6) - 3);
               2: v[k] = 16'($signed($urandom_range(0, 2000)) - 1000);
               default: v[k] = RAW_W'($urandom);
            endcase
         end
         send_sample(v[0], v[1], v[2]);
      end
   endtask

   initial begin
      sb = new();
      sb.clear_state();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_accel_x_raw = '0;
      req_accel_y_raw = '0;
      req_accel_z_raw = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_SCALE_NUM;
      csr_wdata       = '0;
      idle_cycles     = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero vector, axis extremes, every quadrant, default gain.
      send_sample(0, 0, 0);
      send_sample(16'sh7fff, 0, 0);
      send_sample(16'sh8000, 0, 0);
      send_sample(0, 16'sh7fff, 0);
      send_sample(0, 16'sh8000, 0);
      send_sample(0, 0, 16'sh8000);
      send_sample(1000, 1000, 1000);
      send_sample(-1000, 1000, -1000);
      send_sample(-1000, -1000, 1000);
      send_sample(1000, -500, 16'sh8000);
      send_sample(-1, 1, -1);
      drain();

      // Large gain saturates; a zero denominator behaves as one.
      write_csr(CSR_SCALE_NUM, 17'd1000);
      write_csr(CSR_SCALE_DEN, 17'd0);
      write_csr(CSR_TILT_THR, 17'd0);
      send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_sample(40, -33, 0);
      send_sample(1, 0, 0);
      send_sample(0, 0, 0);
      random_burst(200);
      drain();

      // Tiny gain, huge denominator, threshold beyond range never alerts.
      write_csr(CSR_SCALE_NUM, 17'd1);
      write_csr(CSR_SCALE_DEN, 17'd65535);
      write_csr(CSR_TILT_THR, 17'h1ffff);
      send_sample(16'sh7fff, 16'sh8000, 1);
      random_burst(150);
      drain();

      // Random settings for the remaining bursts.
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_SCALE_NUM, 17'($urandom_range(1, 1023)));
         write_csr(CSR_SCALE_DEN, 17'($urandom_range(1, 65535)));
         write_csr(CSR_TILT_THR, (ph == 3) ? 17'd90000 : 17'($urandom_range(0, 90000)));
         if (ph == 1) write_csr(CSR_UNUSED, 17'($urandom));
         random_burst(110);
         drain();
      end
      write_csr(CSR_SCALE_NUM, 17'd61);
      write_csr(CSR_SCALE_DEN, 17'd1000);
      write_csr(CSR_TILT_THR, 17'd45000);
      random_burst(40);
      drain();

      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
